>>> hdl/sfp_pkg.sv
// sfp_pkg: types and constants for the servo frame parser.
// No dependencies; imported by servo_frame_parser_top.
package sfp_pkg;

   localparam int PAYLOAD_LEN  = 12;
   localparam int NUM_CHANNELS = 6;
   localparam int CHAN_W       = 16;
   localparam int COUNT_W      = 4;

   localparam logic [7:0]        FIRST_SYNC_RESET  = 8'hFF;
   localparam logic [7:0]        SECOND_SYNC_RESET = 8'hEE;
   localparam logic [CHAN_W-1:0] HELD_RESET        = 16'd3000;
   localparam logic [CHAN_W-1:0] HELD_CH3_RESET    = 16'd4095;

   localparam logic CSR_FIRST_SYNC  = 1'b0;
   localparam logic CSR_SECOND_SYNC = 1'b1;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_SYNC = 2'd1,
      PH_DATA = 2'd2,
      PH_CKB  = 2'd3
   } phase_type;

endpackage

>>> hdl/servo_frame_parser_top.sv
// servo_frame_parser_top: sync-framed servo packet parser with Fletcher-style check.
// Depends on sfp_pkg.
//
// Usage:
//   req_* carries one received serial byte per beat. The parser hunts for the
//   first sync byte, then the second, collects 12 payload bytes and two sum
//   bytes. On the second sum byte one beat leaves on rsp_*: rsp_tuser is the
//   frame-ok flag, rsp_tdata the six held channels (updated only on a match).
//   All other bytes produce no result beat.
//   Latency: the result beat is valid the cycle after its sum byte is taken.
//   Throughput: one byte per cycle; every byte is handled in a single
//   registered update of the phase, counter and sum registers.
//   Stall: while a result waits on rsp_tready, bytes are still accepted
//   unless the next byte is itself a second sum byte; that one waits.
//   Reset: phase returns to hunting, sums clear, sync bytes return to
//   0xFF/0xEE, held channels to 3000 (channel three 4095).
//   csr_*: APB-style, register 0 (first sync) at 0x0, register 1 at 0x4.
module servo_frame_parser_top
   import sfp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] rx_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // channel_one .. channel_six, 16 bits each, lowest first
   output logic         rsp_tuser,   // [0] frame_ok
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [7:0]        first_sync_ff, second_sync_ff;
   phase_type         phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]        sum_a_ff, sum_a_in, sum_b_ff, sum_b_in, rx_sum_a_ff, rx_sum_a_in;
   logic [7:0]        staging_ff [PAYLOAD_LEN];
   logic [CHAN_W-1:0] held_ff [NUM_CHANNELS];
   logic [CHAN_W-1:0] staged_chan [NUM_CHANNELS];
   logic              rsp_valid_ff, rsp_valid_in, rsp_ok_ff, rsp_ok_in;
   logic              req_fire, csr_write, stage_write, commit, frame_ok;
   logic [7:0]        rx_byte;

   assign rx_byte   = req_tdata;
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_SECOND_SYNC) ? {24'd0, second_sync_ff}
                                                         : {24'd0, first_sync_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         first_sync_ff  <= FIRST_SYNC_RESET;
         second_sync_ff <= SECOND_SYNC_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_FIRST_SYNC:  first_sync_ff  <= csr_pwdata[7:0];
            CSR_SECOND_SYNC: second_sync_ff <= csr_pwdata[7:0];
            default:         ;
         endcase
      end
   end

   // Only a second sum byte needs the output register.
   assign req_tready = !(phase_ff == PH_CKB && rsp_valid_ff && !rsp_tready);
   assign req_fire   = req_tvalid & req_tready;

   for (genvar k = 0; k < NUM_CHANNELS; k++) begin : g_chan
      assign staged_chan[k] = {staging_ff[2*k], staging_ff[2*k+1]};
      assign rsp_tdata[k*CHAN_W +: CHAN_W] = held_ff[k];
   end

   assign frame_ok = (rx_sum_a_ff == sum_a_ff) && (rx_byte == sum_b_ff);

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      sum_a_in     = sum_a_ff;
      sum_b_in     = sum_b_ff;
      rx_sum_a_in  = rx_sum_a_ff;
      stage_write  = 1'b0;
      commit       = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      if (req_fire) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == first_sync_ff) phase_in = PH_SYNC;
            end
            PH_SYNC: begin
               priority if (rx_byte == second_sync_ff) begin
                  count_in = '0;
                  sum_a_in = '0;
                  sum_b_in = '0;
                  phase_in = PH_DATA;
               end else if (rx_byte != first_sync_ff) begin
                  phase_in = PH_HUNT;
               end
            end
            PH_DATA: begin
               if (count_ff < COUNT_W'(PAYLOAD_LEN)) begin
                  stage_write = 1'b1;
                  count_in    = count_ff + 1'b1;
                  sum_a_in    = sum_a_ff + rx_byte;
                  sum_b_in    = sum_b_ff + sum_a_in;
               end else begin
                  rx_sum_a_in = rx_byte;
                  phase_in    = PH_CKB;
               end
            end
            PH_CKB: begin
               commit       = frame_ok;
               rsp_valid_in = 1'b1;
               rsp_ok_in    = frame_ok;
               phase_in     = PH_HUNT;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         count_ff     <= '0;
         sum_a_ff     <= '0;
         sum_b_ff     <= '0;
         rx_sum_a_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_ok_ff    <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         sum_a_ff     <= sum_a_in;
         sum_b_ff     <= sum_b_in;
         rx_sum_a_ff  <= rx_sum_a_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ok_ff    <= rsp_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_write) staging_ff[count_ff] <= rx_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_CHANNELS; k++) held_ff[k] <= HELD_RESET;
         held_ff[2] <= HELD_CH3_RESET;
      end else if (commit) begin
         for (int k = 0; k < NUM_CHANNELS; k++) held_ff[k] <= staged_chan[k];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(PAYLOAD_LEN))
      else $error("payload count past frame length");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_tready))
         |-> $past(req_fire && phase_ff == PH_CKB))
      else $error("result beat without a second sum byte");

   a_ckb_back_to_hunt: assert property (@(posedge clock) disable iff (reset)
      (req_fire && phase_ff == PH_CKB) |=> phase_ff == PH_HUNT && rsp_valid_ff)
      else $error("sum byte did not close the frame");

   a_ok_commits: assert property (@(posedge clock) disable iff (reset)
      (req_fire && phase_ff == PH_CKB && frame_ok)
         |=> rsp_ok_ff && held_ff[0] == $past(staged_chan[0])
             && held_ff[5] == $past(staged_chan[5]))
      else $error("good frame not committed");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && phase_ff == PH_CKB) |-> !req_tready)
      else $error("pending result could be overwritten");

endmodule

>>> tb/servo_frame_parser_top_test.sv
// servo_frame_parser_top_test: self-checking bench for the sync-framed servo packet parser.
// Feeds byte streams of framed packets and noise, predicts every result beat and compares it.
// Depends on sfp_pkg and servo_frame_parser_top.
module servo_frame_parser_top_test
   import sfp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_PHASES   = 5;
   localparam int PHASE_BYTES  = 280;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 4;
   localparam logic [NUM_CHANNELS*CHAN_W-1:0] HELD_AFTER_RESET =
      {HELD_RESET, HELD_RESET, HELD_RESET, HELD_CH3_RESET, HELD_RESET, HELD_RESET};

   typedef struct packed {
      logic                                   frame_ok;
      logic [NUM_CHANNELS-1:0][CHAN_W-1:0]    channels;
   } frame_result_type;

   typedef struct {
      logic [7:0]                       rx;
      bit                               typed;
      logic                             ok;
      logic [NUM_CHANNELS*CHAN_W-1:0]   chans;
   } directed_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata = 8'h00;      // [7:0] rx_byte
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [95:0]   rsp_tdata;              // channel_one .. channel_six, 16 bits each, lowest first
   logic          rsp_tuser;              // [0] frame_ok
   logic          csr_psel = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite = 1'b0;
   logic [2:0]    csr_paddr = 3'd0;
   logic [31:0]   csr_pwdata = 32'd0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   servo_frame_parser_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // parser state mirrored by the bench
   phase_type                              parse_ph;
   logic [COUNT_W-1:0]                     pay_count;
   logic [7:0]                             sum_a;
   logic [7:0]                             sum_b;
   logic [7:0]                             got_sum_a;
   logic [7:0]                             staging [PAYLOAD_LEN];
   logic [NUM_CHANNELS-1:0][CHAN_W-1:0]    held;
   logic [7:0]                             sync_first;
   logic [7:0]                             sync_second;

   frame_result_type  frame_results_due [$];
   frame_result_type  no_result = '0;
   int             idle_pct = 0;
   int             stall_pct = 0;
   int             holds_asked = 0;
   int             holds_served = 0;
   int             mismatches = 0;
   int             bytes_sent = 0;
   int             frames_seen = 0;
   int             frames_committed = 0;

   directed_row_type directed_rows [24] = '{
      '{8'h00, 1'b0, 1'b0, '0},              // ignored while hunting
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},              // repeated first sync keeps waiting
      '{8'h5A, 1'b0, 1'b0, '0},              // stray byte drops back to hunting
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hEE, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hF4, 1'b0, 1'b0, '0},              // sum A right
      '{8'h00, 1'b1, 1'b0, HELD_AFTER_RESET}, // sum B wrong: reset channels held
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hEE, 1'b0, 1'b0, '0}
   };

   function automatic void clear_parser();
      parse_ph    = PH_HUNT;
      pay_count   = '0;
      sum_a       = '0;
      sum_b       = '0;
      got_sum_a   = '0;
      sync_first  = FIRST_SYNC_RESET;
      sync_second = SECOND_SYNC_RESET;
      foreach (staging[i]) staging[i] = '0;
      for (int k = 0; k < NUM_CHANNELS; k++) held[k] = HELD_RESET;
      held[2] = HELD_CH3_RESET;
   endfunction

   function automatic bit parse_rx_byte(input logic [7:0] rx, output frame_result_type res);
      logic ok;
      res = '0;
      parse_rx_byte = 1'b0;
      case (parse_ph)
         PH_HUNT: begin
            if (rx == sync_first) parse_ph = PH_SYNC;
         end
         PH_SYNC: begin
            if (rx == sync_second) begin
               pay_count = '0;
               sum_a     = '0;
               sum_b     = '0;
               parse_ph  = PH_DATA;
            end else if (rx != sync_first) begin
               parse_ph = PH_HUNT;
            end
         end
         PH_DATA: begin
            if (pay_count < PAYLOAD_LEN) begin
               staging[pay_count] = rx;
               pay_count = pay_count + 1'b1;
               sum_a = sum_a + rx;
               sum_b = sum_b + sum_a;
            end else begin
               got_sum_a = rx;
               parse_ph  = PH_CKB;
            end
         end
         default: begin
            ok = (got_sum_a == sum_a) && (rx == sum_b);
            if (ok)
               for (int k = 0; k < NUM_CHANNELS; k++) held[k] = {staging[2*k], staging[2*k+1]};
            parse_ph = PH_HUNT;
            res.frame_ok = ok;
            res.channels = held;
            parse_rx_byte = 1'b1;
         end
      endcase
   endfunction

   // called at a rising edge; returns at the edge where the beat is taken
   task automatic send_byte(input logic [7:0] rx, input bit typed, input frame_result_type want);
      frame_result_type res;
      bit            has;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      has = parse_rx_byte(rx, res);
      if (typed) frame_results_due.push_back(want);
      else if (has) frame_results_due.push_back(res);
      bytes_sent++;
   endtask

   task automatic send_random_frame();
      logic [7:0] frame_q [$];
      logic [7:0] fa;
      logic [7:0] fb;
      logic [7:0] b;
      int         kind;
      int         n;
      kind = $urandom_range(99);
      fa = '0;
      fb = '0;
      if (kind >= 90) begin
         n = $urandom_range(6, 1);
         repeat (n) frame_q.push_back(8'($urandom_range(255)));
      end else begin
         if ($urandom_range(3) == 0) frame_q.push_back(8'($urandom_range(255)));
         frame_q.push_back(sync_first);
         n = ($urandom_range(3) == 0 && sync_first != sync_second) ? $urandom_range(2, 1) : 0;
         repeat (n) frame_q.push_back(sync_first);
         frame_q.push_back(sync_second);
         for (int i = 0; i < PAYLOAD_LEN; i++) begin
            case ($urandom_range(7))
               0: b = 8'h00;
               1: b = 8'hFF;
               default: b = 8'($urandom_range(255));
            endcase
            fa = fa + b;
            fb = fb + fa;
            frame_q.push_back(b);
         end
         if (kind < 70) begin
            frame_q.push_back(fa);
            frame_q.push_back(fb);
         end else if (kind < 80) begin
            b = 8'($urandom_range(255, 1));
            if ($urandom_range(1)) fa = fa ^ b;
            else fb = fb ^ b;
            frame_q.push_back(fa);
            frame_q.push_back(fb);
         end else begin
            n = $urandom_range(10, 1);
            repeat (n) void'(frame_q.pop_back());
         end
      end
      foreach (frame_q[i]) send_byte(frame_q[i], 1'b0, no_result);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (frame_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic sel, input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (sel == CSR_FIRST_SYNC) sync_first = value;
      else sync_second = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // receiver pacing; a long hold-off lets the parser back up into req_tready
   initial begin
      forever begin
         @(posedge clock);
         if (holds_served != holds_asked) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            holds_served++;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      frame_result_type head;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (frame_results_due.size() == 0) begin
            $display("%0t: unexpected result beat ok=%0d data=%h", $time, rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            head = frame_results_due.pop_front();
            frames_seen++;
            if (head.frame_ok) frames_committed++;
            if (rsp_tuser !== head.frame_ok) begin
               $display("%0t: frame_ok expected %0d actual %0d", $time, head.frame_ok, rsp_tuser);
               mismatches++;
            end
            for (int k = 0; k < NUM_CHANNELS; k++)
               if (rsp_tdata[k*CHAN_W +: CHAN_W] !== head.channels[k]) begin
                  $display("%0t: channel %0d expected %h actual %h", $time, k + 1,
                           head.channels[k], rsp_tdata[k*CHAN_W +: CHAN_W]);
                  mismatches++;
               end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("servo_frame_parser_top test failed");
      $finish;
   end

   initial begin
      int           send_idle [NUM_PHASES] = '{0, 0, 65, 8, 0};
      int           recv_stall [NUM_PHASES] = '{0, 65, 0, 8, 0};
      logic [7:0]   v;
      int           start;
      clear_parser();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         send_byte(directed_rows[i].rx, directed_rows[i].typed,
                   '{frame_ok: directed_rows[i].ok, channels: directed_rows[i].chans});
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         case (p)
            1: begin
               write_csr(CSR_FIRST_SYNC, 8'h00);
               write_csr(CSR_SECOND_SYNC, 8'hFF);
            end
            2: begin
               write_csr(CSR_FIRST_SYNC, 8'hFF);
               write_csr(CSR_SECOND_SYNC, 8'h00);
            end
            3: begin
               v = 8'($urandom_range(255));
               write_csr(CSR_FIRST_SYNC, v);
               write_csr(CSR_SECOND_SYNC, v);
            end
            4: begin
               write_csr(CSR_FIRST_SYNC, 8'($urandom_range(255)));
               write_csr(CSR_SECOND_SYNC, 8'($urandom_range(255)));
               holds_asked++;
            end
            default: ;
         endcase
         idle_pct  = send_idle[p];
         stall_pct = recv_stall[p];
         start = bytes_sent;
         while (bytes_sent - start < PHASE_BYTES) send_random_frame();
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (frame_results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Sent %0d bytes over %0d sync settings and four pacing modes;", bytes_sent,
               NUM_PHASES);
      $display("checked %0d frame results, %0d of them committing new channels.", frames_seen,
               frames_committed);
      if (mismatches == 0) $display("servo_frame_parser_top test passed");
      else $display("servo_frame_parser_top test failed");
      $finish;
   end

endmodule

>>> servo_frame_parser_top.f
hdl/sfp_pkg.sv
hdl/servo_frame_parser_top.sv
tb/servo_frame_parser_top_test.sv
